// ===== rtl/pics_pkg.sv =====
// ----------------------------------------------------------------------------
// pics_pkg
// Shared constants, types and helpers of the point-in-sector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pics_pkg;

    // Default sizes
    localparam int COORD_BITS_DEF     = 16;
    localparam int ANGLE_ITER_DEF     = 16;
    localparam int ATAN_LEN           = 24;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 3;
    localparam logic [2:0]  REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0]  REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0]  REG_FACING_X   = 3'd2;
    localparam logic [2:0]  REG_FACING_Y   = 3'd3;
    localparam logic [2:0]  REG_REACH      = 3'd4;
    localparam logic [2:0]  REG_HALF_ANGLE = 3'd5;

    // Angle in whole degrees, 0..359
    localparam int DEG_W = 9;
    typedef logic [DEG_W-1:0] t_deg;

    // CORDIC fixed point
    localparam int PRE_SHIFT_BITS = 14;   // coordinates scaled by 2^14
    localparam int CORDIC_GUARD   = 18;   // sign, negation, scale and gain growth
    localparam int FRAC_BITS      = 30;   // angle accumulator is Q30 radians
    localparam int Z_W            = 35;
    localparam logic signed [Z_W-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] Q30_HALF_PI = 35'sd1686629713;

    localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // Radians to degrees: deg = trunc(z * 9000 / (157 * 2^30))
    localparam int DEG_MUL    = 9000;
    localparam int DEG_DEN    = 157;
    localparam int M_W        = 17;       // (|z| * 9000) >> 30
    localparam int Q_W        = 10;       // quotient estimate
    localparam int REC_SHIFT  = 24;
    localparam int REC_K      = 106861;   // floor(2^24 / 157)
    localparam int DEG_FULL   = 360;

    // Stages in one angle lane: setup, one per iteration, three to degrees
    function automatic int angle_lat(input int iter);
        return iter + 4;
    endfunction

    // Config data must hold a coordinate and the 9-bit half angle
    function automatic int cfg_data_w(input int coord_bits);
        return (coord_bits > DEG_W) ? coord_bits : DEG_W;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pics_if.sv =====
// ----------------------------------------------------------------------------
// pics_if
// Request, result and configuration channels of the point-in-sector unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface pics_target_if #(
    parameter int COORD_BITS = pics_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;

    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface pics_result_if;
    logic            valid;
    logic            ready;
    logic            inside_res;
    pics_pkg::t_deg  target_angle;

    modport source (output valid, output inside_res, output target_angle, input ready);
    modport sink   (input valid, input inside_res, input target_angle, output ready);
endinterface

interface pics_cfg_if #(
    parameter int DATA_W = pics_pkg::cfg_data_w(pics_pkg::COORD_BITS_DEF)
);
    logic                              valid;
    logic                              ready;
    logic [pics_pkg::CFG_IDX_W-1:0]    index;
    logic [DATA_W-1:0]                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pics_angle.sv =====
// ----------------------------------------------------------------------------
// pics_angle
// Pipelined vectoring CORDIC plus radians-to-degrees conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module pics_angle #(
    parameter int COORD_BITS       = pics_pkg::COORD_BITS_DEF,
    parameter int ANGLE_ITERATIONS = pics_pkg::ANGLE_ITER_DEF
) (
    input  wire logic                                              i_clk,
    input  wire logic [pics_pkg::angle_lat(ANGLE_ITERATIONS)-1:0]  i_en,
    input  wire logic signed [COORD_BITS:0]                        i_dx,
    input  wire logic signed [COORD_BITS:0]                        i_dy,
    output pics_pkg::t_deg                                         o_deg
);

    localparam int N  = ANGLE_ITERATIONS;
    localparam int W  = COORD_BITS + pics_pkg::CORDIC_GUARD;
    localparam int ZW = pics_pkg::Z_W;
    localparam int MW = pics_pkg::M_W;
    localparam int QW = pics_pkg::Q_W;

    // Setup: fold left half plane, detect axis points
    logic signed [COORD_BITS+1:0] w_dx_e, w_dy_e, w_ax, w_ay;
    logic signed [W-1:0]          n_x0, n_y0;
    logic signed [ZW-1:0]         n_z0;
    logic                         n_sp0;

    always_comb begin
        w_dx_e = (COORD_BITS+2)'(i_dx);
        w_dy_e = (COORD_BITS+2)'(i_dy);
        w_ax   = (i_dx < 0) ? -w_dx_e : w_dx_e;
        w_ay   = (i_dx < 0) ? -w_dy_e : w_dy_e;
        n_x0   = W'(w_ax) <<< pics_pkg::PRE_SHIFT_BITS;
        n_y0   = W'(w_ay) <<< pics_pkg::PRE_SHIFT_BITS;
        n_sp0  = (i_dy == '0) || (i_dx == '0);
        if (i_dy == '0) begin
            n_z0 = (i_dx < 0) ? pics_pkg::Q30_PI : '0;
        end else if (i_dx == '0) begin
            n_z0 = (i_dy > 0) ? pics_pkg::Q30_HALF_PI : -pics_pkg::Q30_HALF_PI;
        end else if (i_dx < 0) begin
            n_z0 = (i_dy > 0) ? pics_pkg::Q30_PI : -pics_pkg::Q30_PI;
        end else begin
            n_z0 = '0;
        end
    end

    // Iteration stages; entry 0 is the setup register
    logic signed [W-1:0]  r_x  [N+1];
    logic signed [W-1:0]  r_y  [N+1];
    logic signed [ZW-1:0] r_z  [N+1];
    logic                 r_sp [N+1];

    logic signed [W-1:0]  n_x  [N];
    logic signed [W-1:0]  n_y  [N];
    logic signed [ZW-1:0] n_z  [N];

    always_comb begin
        logic signed [W-1:0]  xs;
        logic signed [W-1:0]  ys;
        logic signed [ZW-1:0] at;
        for (int k = 0; k < N; k++) begin
            xs = r_x[k] >>> k;
            ys = r_y[k] >>> k;
            at = ZW'(pics_pkg::ATAN_Q30[k]);
            if (r_sp[k]) begin
                n_x[k] = r_x[k];
                n_y[k] = r_y[k];
                n_z[k] = r_z[k];
            end else if (r_y[k] > 0) begin
                n_x[k] = r_x[k] + ys;
                n_y[k] = r_y[k] - xs;
                n_z[k] = r_z[k] + at;
            end else begin
                n_x[k] = r_x[k] - ys;
                n_y[k] = r_y[k] + xs;
                n_z[k] = r_z[k] - at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_sp[0] <= n_sp0;
        end
        for (int k = 0; k < N; k++) begin
            if (i_en[k+1]) begin
                r_x[k+1]  <= n_x[k];
                r_y[k+1]  <= n_y[k];
                r_z[k+1]  <= n_z[k];
                r_sp[k+1] <= r_sp[k];
            end
        end
    end

    // Degrees, stage 1: m = (|z| * 9000) >> 30
    logic [ZW-2:0]  w_mag;
    logic [ZW+13:0] w_prod;
    logic [MW-1:0]  r_m1;
    logic           r_neg1;

    assign w_mag  = r_z[N][ZW-1] ? (ZW-1)'(-r_z[N]) : (ZW-1)'(r_z[N]);
    assign w_prod = (ZW+14)'(w_mag) * (ZW+14)'(pics_pkg::DEG_MUL);

    // Stage 2: q0 = m / 157 by reciprocal, may be one low
    logic [MW+16:0] w_rec;
    logic [QW-1:0]  r_q0;
    logic [MW-1:0]  r_m2;
    logic           r_neg2;

    assign w_rec = (MW+17)'(r_m1) * (MW+17)'(pics_pkg::REC_K);

    // Stage 3: fix up quotient, apply sign, wrap to 0..359
    logic [MW:0]     w_rem;
    logic [QW-1:0]   w_q;
    pics_pkg::t_deg  n_deg;
    pics_pkg::t_deg  r_deg;

    always_comb begin
        w_rem = {1'b0, r_m2} - (MW+1)'((MW+1)'(r_q0) * (MW+1)'(pics_pkg::DEG_DEN));
        w_q   = (w_rem >= (MW+1)'(pics_pkg::DEG_DEN)) ? r_q0 + QW'(1) : r_q0;
        if (r_neg2 && (w_q != '0)) begin
            n_deg = pics_pkg::DEG_W'(pics_pkg::DEG_FULL) - pics_pkg::DEG_W'(w_q);
        end else if (r_neg2) begin
            n_deg = '0;
        end else begin
            n_deg = pics_pkg::DEG_W'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[N+1]) begin
            r_m1   <= w_prod[pics_pkg::FRAC_BITS +: MW];
            r_neg1 <= r_z[N][ZW-1];
        end
        if (i_en[N+2]) begin
            r_q0   <= w_rec[pics_pkg::REC_SHIFT +: QW];
            r_m2   <= r_m1;
            r_neg2 <= r_neg1;
        end
        if (i_en[N+3]) begin
            r_deg  <= n_deg;
        end
    end

    assign o_deg = r_deg;

endmodule

`default_nettype wire

// ===== rtl/point_in_circular_sector_unit.sv =====
// ----------------------------------------------------------------------------
// point_in_circular_sector_unit
// Tests streamed points against a configured circular sector.
//
// Program the apex (origin), the point the sector faces, the radius (reach)
// and the half opening in degrees through the config channel, then stream
// target points in. Each request yields one result: inside_res and the
// target's angle seen from the apex in whole degrees 0..359 (y grows
// downward, angle measured counterclockwise on screen from +x, scaled by
// 180/3.14 and truncated). A target at or beyond the radius reports 0/0.
// The unit takes one request per cycle unless backpressure has filled the
// pipe, which holds the input register, the distance stage, the unrolled
// CORDIC (one stage per iteration) with its setup and degree conversion
// stages, and the output register. Backpressure on the result side stalls
// only the stages that are full, so empty slots keep absorbing requests.
// Write config only while no request is in flight; writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_circular_sector_unit #(
    parameter int COORD_BITS       = pics_pkg::COORD_BITS_DEF,
    parameter int ANGLE_ITERATIONS = pics_pkg::ANGLE_ITER_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pics_target_if.sink      i_target,
    pics_result_if.source    o_result,
    pics_cfg_if.sink         i_cfg
);

    localparam int C  = COORD_BITS;
    localparam int LA = pics_pkg::angle_lat(ANGLE_ITERATIONS);
    // input reg, distance reg, angle lane, output reg
    localparam int D  = LA + 3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [C-1:0] r_origin_x, r_origin_y, r_facing_x, r_facing_y;
    logic        [C-1:0] r_reach;
    pics_pkg::t_deg      r_half;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_facing_x <= C'(1);
            r_facing_y <= '0;
            r_reach    <= '0;
            r_half     <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pics_pkg::REG_ORIGIN_X:   r_origin_x <= i_cfg.data[C-1:0];
                pics_pkg::REG_ORIGIN_Y:   r_origin_y <= i_cfg.data[C-1:0];
                pics_pkg::REG_FACING_X:   r_facing_x <= i_cfg.data[C-1:0];
                pics_pkg::REG_FACING_Y:   r_facing_y <= i_cfg.data[C-1:0];
                pics_pkg::REG_REACH:      r_reach    <= i_cfg.data[C-1:0];
                pics_pkg::REG_HALF_ANGLE: r_half     <= i_cfg.data[pics_pkg::DEG_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or the stage
    // after it loads too. Stage D-1 is the result register.
    // ------------------------------------------------------------------
    logic [D-1:0] r_v;
    logic [D:0]   w_en;

    always_comb begin
        w_en[D] = o_result.ready;
        for (int k = D - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_target.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_target.valid;
            end
            for (int k = 1; k < D; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: request register
    // ------------------------------------------------------------------
    logic signed [C-1:0] r_tx, r_ty;

    // Stage 1: offsets from the apex and squared terms
    logic signed [C:0]     n_dx, n_dy;
    logic signed [2*C+1:0] n_sq_x, n_sq_y;
    logic signed [C:0]     r_dx, r_dy;
    logic        [2*C:0]   r_sq_x, r_sq_y;
    logic        [2*C-1:0] r_r2;

    assign n_dx   = (C+1)'(r_tx) - (C+1)'(r_origin_x);
    assign n_dy   = (C+1)'(r_origin_y) - (C+1)'(r_ty);
    assign n_sq_x = (2*C+2)'(n_dx) * (2*C+2)'(n_dx);
    assign n_sq_y = (2*C+2)'(n_dy) * (2*C+2)'(n_dy);

    // Facing offsets; user holds config static while requests are in flight
    logic signed [C:0] w_fdx, w_fdy;

    assign w_fdx = (C+1)'(r_facing_x) - (C+1)'(r_origin_x);
    assign w_fdy = (C+1)'(r_origin_y) - (C+1)'(r_facing_y);

    // Stage 2 onward: out-of-range flag, carried alongside the angle lanes
    logic        w_far;
    logic [LA-1:0] r_far;

    assign w_far = ({1'b0, r_sq_x} + {1'b0, r_sq_y}) >= (2*C+2)'(r_r2);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_tx <= i_target.target_x;
            r_ty <= i_target.target_y;
        end
        if (w_en[1]) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_sq_x <= n_sq_x[2*C:0];
            r_sq_y <= n_sq_y[2*C:0];
            r_r2   <= (2*C)'(r_reach) * (2*C)'(r_reach);
        end
        if (w_en[2]) begin
            r_far[0] <= w_far;
        end
        for (int j = 1; j < LA; j++) begin
            if (w_en[2+j]) begin
                r_far[j] <= r_far[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle lanes: target and facing point, in lockstep
    // ------------------------------------------------------------------
    pics_pkg::t_deg w_tdeg, w_fdeg;

    pics_angle #(
        .COORD_BITS       (COORD_BITS),
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_target_angle (
        .i_clk (i_clk),
        .i_en  (w_en[2 +: LA]),
        .i_dx  (r_dx),
        .i_dy  (r_dy),
        .o_deg (w_tdeg)
    );

    pics_angle #(
        .COORD_BITS       (COORD_BITS),
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_facing_angle (
        .i_clk (i_clk),
        .i_en  (w_en[2 +: LA]),
        .i_dx  (w_fdx),
        .i_dy  (w_fdy),
        .o_deg (w_fdeg)
    );

    // ------------------------------------------------------------------
    // Result stage: sector bounds (mod 360) and range test; the range may
    // wrap through zero, in which case either side of it counts.
    // ------------------------------------------------------------------
    logic signed [10:0] w_lo;
    logic        [10:0] w_hi;
    logic               w_in;
    logic               r_inside;
    pics_pkg::t_deg     r_angle;

    always_comb begin
        w_lo = signed'({2'b00, w_fdeg}) - signed'({2'b00, r_half});
        if (w_lo < 0) begin
            w_lo = w_lo + 11'sd360;
        end
        if (w_lo < 0) begin
            w_lo = w_lo + 11'sd360;
        end
        w_hi = {2'b00, w_fdeg} + {2'b00, r_half};
        if (w_hi >= 11'(pics_pkg::DEG_FULL)) begin
            w_hi = w_hi - 11'(pics_pkg::DEG_FULL);
        end
        if (w_hi >= 11'(pics_pkg::DEG_FULL)) begin
            w_hi = w_hi - 11'(pics_pkg::DEG_FULL);
        end
        if (11'(w_lo) <= w_hi) begin
            w_in = ({2'b00, w_tdeg} >= 11'(w_lo)) && ({2'b00, w_tdeg} <= w_hi);
        end else begin
            w_in = ({2'b00, w_tdeg} <= w_hi) || ({2'b00, w_tdeg} >= 11'(w_lo));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[D-1]) begin
            r_inside <= !r_far[LA-1] && w_in;
            r_angle  <= r_far[LA-1] ? '0 : w_tdeg;
        end
    end

    assign o_result.valid        = r_v[D-1];
    assign o_result.inside_res   = r_inside;
    assign o_result.target_angle = r_angle;

endmodule

`default_nettype wire
